// ===== hdl/uopt_pkg.sv =====
// Shared types and constants for the unicycle offset-point tracking core.
// No dependencies.
package uopt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int WIDE_W = 40;
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 40'sd274877906943;
    localparam logic signed [34:0] CORDIC_GAIN_Q30 = 35'sd652032875;

    localparam logic [16:0] OFFSET_RESET = 17'd4915;
    localparam logic [18:0] GAIN_RESET = 19'd49152;

    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_GAIN = 1'b1;
    localparam logic REQ_ODOM = 1'b0;

    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic               is_ref;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] yaw_rate;
    } t_item;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] turn;
    } t_result;

    function automatic logic [31:0] angle_step(input logic [4:0] i);
        case (i)
            5'd0: return 32'h20000000;
            5'd1: return 32'h12E4051E;
            5'd2: return 32'h09FB385B;
            5'd3: return 32'h051111D4;
            5'd4: return 32'h028B0D43;
            5'd5: return 32'h0145D7E1;
            5'd6: return 32'h00A2F61E;
            5'd7: return 32'h00517C55;
            5'd8: return 32'h0028BE53;
            5'd9: return 32'h00145F2F;
            5'd10: return 32'h000A2F98;
            5'd11: return 32'h000517CC;
            5'd12: return 32'h00028BE6;
            5'd13: return 32'h000145F3;
            5'd14: return 32'h0000A2FA;
            5'd15: return 32'h0000517D;
            5'd16: return 32'h000028BE;
            5'd17: return 32'h0000145F;
            5'd18: return 32'h00000A30;
            5'd19: return 32'h00000518;
            5'd20: return 32'h0000028C;
            5'd21: return 32'h00000146;
            5'd22: return 32'h000000A3;
            5'd23: return 32'h00000051;
            default: return 32'h0;
        endcase
    endfunction

    function automatic t_wide sat_wide(input logic signed [WIDE_W+1:0] v);
        if (v > 42'(WIDE_MAX)) return WIDE_MAX;
        if (v < -42'(WIDE_MAX)) return -WIDE_MAX;
        return WIDE_W'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide v);
        if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -40'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== hdl/uopt_front.sv =====
// Front end: accepts items, stores odometry, and queues reference items.
// Depends on uopt_pkg.
module uopt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  uopt_pkg::t_item       i_item,
    output logic                  o_full,
    output logic signed [31:0]    o_pose_x,
    output logic signed [31:0]    o_pose_y,
    output logic signed [15:0]    o_pose_heading,
    output logic                  o_q_valid,
    output uopt_pkg::t_item       o_q_item,
    input  logic                  i_q_take
);
    import uopt_pkg::*;

    // Two-entry queue toward the back end.
    t_item      r_mem [2];
    // Each queued reference item carries the pose in force when it was accepted.
    logic signed [31:0] r_pmx [2];
    logic signed [31:0] r_pmy [2];
    logic signed [15:0] r_pmh [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_ph;
    logic       w_acc, w_wr;

    assign o_full = (r_cnt == 2'd2);
    assign w_acc = i_push && !o_full;
    assign w_wr = w_acc && i_item.is_ref;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item = r_mem[r_rp];
    assign o_pose_x = r_pmx[r_rp];
    assign o_pose_y = r_pmy[r_rp];
    assign o_pose_heading = r_pmh[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_px <= '0;
            r_py <= '0;
            r_ph <= '0;
        end else begin
            if (w_acc && i_item.is_ref == REQ_ODOM) begin
                r_px <= i_item.pos_x;
                r_py <= i_item.pos_y;
                r_ph <= i_item.heading;
            end
            if (w_wr) r_wp <= ~r_wp;
            if (i_q_take && o_q_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(i_q_take && o_q_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
            r_pmx[r_wp] <= r_px;
            r_pmy[r_wp] <= r_py;
            r_pmh[r_wp] <= r_ph;
        end
    end
endmodule

// ===== hdl/uopt_cordic.sv =====
// Iterative CORDIC sine and cosine of a 16-bit binary angle, Q.FRAC_BITS out.
// Depends on uopt_pkg.
module uopt_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output uopt_pkg::t_wide    o_cos,
    output uopt_pkg::t_wide    o_sin
);
    import uopt_pkg::*;

    logic signed [34:0] r_x, r_y;
    logic [31:0] r_z;
    logic [4:0]  r_i;
    logic        r_busy, r_flip, r_done;
    logic signed [34:0] w_xs, w_ys, w_xf, w_yf;
    logic [31:0] w_z0;
    logic [1:0]  w_q;

    assign w_z0 = {i_angle, 16'h0};
    assign w_q = w_z0[31:30];
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_xf = r_flip ? -r_x : r_x;
    assign w_yf = r_flip ? -r_y : r_y;
    assign o_done = r_done;
    assign o_cos = WIDE_W'((w_xf + 35'(1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    assign o_sin = WIDE_W'((w_yf + 35'(1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i <= '0;
                r_x <= CORDIC_GAIN_Q30;
                r_y <= '0;
                r_flip <= (w_q == 2'd1 || w_q == 2'd2);
                r_z <= (w_q == 2'd1 || w_q == 2'd2) ? (w_z0 ^ 32'h80000000) : w_z0;
            end else if (r_busy) begin
                if (r_z[31]) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + angle_step(r_i);
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - angle_step(r_i);
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/uopt_back.sv =====
// Back end: sequencer with one shared multiplier, CORDIC and a serial divider.
// Depends on uopt_pkg and uopt_cordic.
module uopt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  uopt_pkg::t_item    i_q_item,
    output logic               o_q_take,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_pose_heading,
    input  logic [16:0]        i_eps,
    input  logic [18:0]        i_gain,
    output logic               o_res_valid,
    output uopt_pkg::t_result  o_res,
    input  logic               i_res_take
);
    import uopt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_COS1, S_COS2, S_MUL, S_DIV, S_OUT, S_HOLD
    } t_state;

    t_state r_state;
    logic [4:0] r_step;
    t_wide r_eps, r_k, r_c, r_s, r_cd, r_sd, r_zxc, r_zyc, r_zxr, r_zyr;
    t_wide r_ew, r_zxd, r_zyd, r_u1, r_u2, r_v, r_num, r_tmp;
    t_wide r_ma, r_p;
    logic signed [20:0] r_mb;
    logic signed [41:0] r_plo;
    logic  r_mv, r_mv2;
    t_item r_it;
    logic [55:0] r_rem;
    logic [55:0] r_quo;
    logic [5:0]  r_dcnt;
    logic        r_neg;
    t_result r_res;
    logic        r_cs;
    logic signed [15:0] r_ang;
    logic        w_cd;
    t_wide       w_cc, w_cs2;
    logic signed [41:0] w_plo;
    logic signed [40:0] w_phi;
    logic signed [63:0] w_full;
    t_wide       w_fm;
    logic [56:0] w_sub;
    t_wide       w_qs;
    t_wide       w_w;

    uopt_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_cs), .i_angle(r_ang),
        .o_done(w_cd), .o_cos(w_cc), .o_sin(w_cs2)
    );

    // The wide operand is split in two halves: the low partial product is
    // registered first, the high one is added and rounded in the following cycle.
    assign w_plo = $signed({1'b0, r_ma[19:0]}) * r_mb;
    assign w_phi = $signed(r_ma[WIDE_W-1:20]) * r_mb;
    assign w_full = (64'(w_phi) <<< 20) + 64'(r_plo) + (64'sd1 <<< (FRAC_BITS - 1));
    assign w_fm = sat_wide(42'(w_full >>> FRAC_BITS));
    assign w_sub = {r_rem, r_quo[55]} - {17'd0, r_eps};
    assign w_qs = (r_quo > 56'(WIDE_MAX)) ? WIDE_MAX : WIDE_W'(r_quo);
    assign w_w = r_neg ? -w_qs : w_qs;

    assign o_q_take = (r_state == S_IDLE) && i_q_valid;
    assign o_res_valid = (r_state == S_HOLD);
    assign o_res = r_res;

    // Each multiply step loads the operands; the low partial product and then the result r_p are registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cs <= 1'b0;
            r_mv <= 1'b0;
            r_mv2 <= 1'b0;
        end else begin
            r_cs <= 1'b0;
            r_mv <= 1'b0;
            r_mv2 <= r_mv;
            if (r_mv) r_plo <= w_plo;
            if (r_mv2) r_p <= w_fm;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_it <= i_q_item;
                        r_eps <= (i_eps == 17'd0) ? WIDE_W'(1) : WIDE_W'(i_eps);
                        r_k <= WIDE_W'(i_gain);
                        r_ang <= i_pose_heading;
                        r_zxc <= WIDE_W'(i_pose_x);
                        r_zyc <= WIDE_W'(i_pose_y);
                        r_cs <= 1'b1;
                        r_state <= S_COS1;
                    end
                end
                S_COS1: begin
                    if (w_cd) begin
                        r_c <= w_cc;
                        r_s <= w_cs2;
                        r_ang <= r_it.heading;
                        r_cs <= 1'b1;
                        r_state <= S_COS2;
                    end
                end
                S_COS2: begin
                    if (w_cd) begin
                        r_cd <= w_cc;
                        r_sd <= w_cs2;
                        r_step <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!r_mv) r_step <= r_step + 5'd1;
                    // Even steps take the last product and issue the next (step 0 only
                    // issues, step 30 starts the divider); odd steps wait for the multiplier.
                    case (r_step)
                        5'd0: begin r_ma <= r_eps; r_mb <= 21'(r_c); r_mv <= 1'b1; end
                        5'd2: begin r_zxc <= sat_wide(42'(r_zxc) + 42'(r_p));
                            r_ma <= r_eps; r_mb <= 21'(r_s); r_mv <= 1'b1; end
                        5'd4: begin r_zyc <= sat_wide(42'(r_zyc) + 42'(r_p));
                            r_ma <= r_eps; r_mb <= 21'(r_cd); r_mv <= 1'b1; end
                        5'd6: begin
                            r_zxr <= sat_wide(42'(r_it.pos_x) + 42'(r_p));
                            r_ma <= r_eps; r_mb <= 21'(r_sd); r_mv <= 1'b1; end
                        5'd8: begin
                            r_zyr <= sat_wide(42'(r_it.pos_y) + 42'(r_p));
                            r_ma <= WIDE_W'(r_it.yaw_rate); r_mb <= 21'(r_eps);
                            r_mv <= 1'b1; end
                        5'd10: begin r_ew <= r_p;
                            r_ma <= r_p; r_mb <= 21'(r_sd); r_mv <= 1'b1; end
                        5'd12: begin
                            r_zxd <= sat_wide(42'(r_it.vel_x) - 42'(r_p));
                            r_ma <= r_ew; r_mb <= 21'(r_cd); r_mv <= 1'b1; end
                        5'd14: begin
                            r_zyd <= sat_wide(42'(r_it.vel_y) + 42'(r_p));
                            r_ma <= sat_wide(42'(r_zxc) - 42'(r_zxr));
                            r_mb <= 21'(r_k);
                            r_mv <= 1'b1; end
                        5'd16: begin r_u1 <= sat_wide(42'(r_zxd) - 42'(r_p));
                            r_ma <= sat_wide(42'(r_zyc) - 42'(r_zyr));
                            r_mb <= 21'(r_k);
                            r_mv <= 1'b1; end
                        5'd18: begin r_u2 <= sat_wide(42'(r_zyd) - 42'(r_p));
                            r_ma <= r_u1; r_mb <= 21'(r_c); r_mv <= 1'b1; end
                        5'd20: begin r_tmp <= r_p;
                            r_ma <= r_u2; r_mb <= 21'(r_s); r_mv <= 1'b1; end
                        5'd22: begin r_v <= sat_wide(42'(r_tmp) + 42'(r_p));
                            r_ma <= r_u2; r_mb <= 21'(r_c); r_mv <= 1'b1; end
                        5'd24: begin r_tmp <= r_p;
                            r_ma <= r_u1; r_mb <= 21'(r_s); r_mv <= 1'b1; end
                        5'd26: begin r_num <= sat_wide(42'(r_tmp) - 42'(r_p));
                            r_ma <= r_v; r_mb <= 21'(r_c); r_mv <= 1'b1; end
                        5'd28: begin r_res.vel_x <= sat32(r_p);
                            r_ma <= r_v; r_mb <= 21'(r_s); r_mv <= 1'b1; end
                        5'd30: begin
                            r_res.vel_y <= sat32(r_p);
                            r_neg <= r_num[WIDE_W-1];
                            r_quo <= 56'(r_num[WIDE_W-1] ? -r_num : r_num)
                                << FRAC_BITS;
                            r_rem <= '0;
                            r_dcnt <= '0;
                            r_state <= S_DIV;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (!w_sub[56]) begin
                        r_rem <= w_sub[55:0];
                        r_quo <= {r_quo[54:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[54:0], r_quo[55]};
                        r_quo <= {r_quo[54:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd55) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res.turn <= sat32(w_w);
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_res_take) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/uopt_outq.sv =====
// Two-entry result queue feeding the output ports.
// Depends on uopt_pkg.
module uopt_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  uopt_pkg::t_result i_res,
    output logic              o_take,
    output logic              o_empty,
    output uopt_pkg::t_result o_res,
    input  logic              i_pop
);
    import uopt_pkg::*;

    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_take = i_valid && (r_cnt != 2'd2);
    assign w_wr = o_take;
    assign o_empty = (r_cnt == 2'd0);
    assign w_rd = i_pop && !o_empty;
    assign o_res = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_res;
    end
endmodule

// ===== hdl/unicycle_offset_point_tracking_core.sv =====
// Offset-point tracking core: a reference item passes through two CORDIC passes,
// 15 products on one shared two-pass multiplier and a serial divider before its
// result appears; odometry items only update the stored pose. The back end
// takes a new reference item only once the last result is queued. Synchronous
// active-low reset empties the queues, zeroes the pose and restores config defaults.
// Depends on uopt_pkg, uopt_front, uopt_back, uopt_outq.
module unicycle_offset_point_tracking_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_req_type,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    input  logic signed [31:0] i_ref_vel_x,
    input  logic signed [31:0] i_ref_vel_y,
    input  logic signed [31:0] i_ref_yaw_rate,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_cmd_vel_x,
    output logic signed [31:0] o_cmd_vel_y,
    output logic signed [31:0] o_cmd_turn_rate,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [18:0]        i_cfg_data
);
    import uopt_pkg::*;

    t_item   w_item, w_qitem;
    t_result w_res, w_out;
    logic    w_qv, w_take, w_rv, w_rtake;
    logic signed [31:0] w_px, w_py;
    logic signed [15:0] w_ph;
    logic [16:0] r_eps;
    logic [18:0] r_gain;

    assign w_item = '{is_ref: i_req_type, pos_x: i_pos_x, pos_y: i_pos_y,
        heading: i_heading, vel_x: i_ref_vel_x, vel_y: i_ref_vel_y,
        yaw_rate: i_ref_yaw_rate};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= OFFSET_RESET;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_OFFSET) r_eps <= i_cfg_data[16:0];
            if (i_cfg_index == REG_GAIN) r_gain <= i_cfg_data;
        end
    end

    uopt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(w_item),
        .o_full(full), .o_pose_x(w_px), .o_pose_y(w_py),
        .o_pose_heading(w_ph), .o_q_valid(w_qv), .o_q_item(w_qitem),
        .i_q_take(w_take)
    );

    uopt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .i_q_item(w_qitem),
        .o_q_take(w_take), .i_pose_x(w_px), .i_pose_y(w_py),
        .i_pose_heading(w_ph), .i_eps(r_eps), .i_gain(r_gain),
        .o_res_valid(w_rv), .o_res(w_res), .i_res_take(w_rtake)
    );

    uopt_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_rv), .i_res(w_res),
        .o_take(w_rtake), .o_empty(empty), .o_res(w_out), .i_pop(pop)
    );

    assign o_cmd_vel_x = w_out.vel_x;
    assign o_cmd_vel_y = w_out.vel_y;
    assign o_cmd_turn_rate = w_out.turn;
endmodule
